### sv/sts_pkg.sv
// shared types, token codes and keyword tables for the script token scanner
package sts_pkg;

  localparam int POSITION_BITS = 24;
  localparam int OUT_POS_BITS  = 24;
  localparam int LINE_BITS     = 24;
  localparam int KIND_BITS     = 5;
  localparam int CFG_BITS      = 16;
  localparam int NUM_KW        = 8;
  localparam int KW_MAX_LEN    = 5;
  localparam int WLEN_BITS     = 3;
  localparam int TOKQ_DEPTH    = 4;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_DECIMAL = 3'd2,
    MODE_IDENT   = 3'd3,
    MODE_EQ      = 3'd4,
    MODE_GT      = 3'd5,
    MODE_LT      = 3'd6,
    MODE_STRING  = 3'd7
  } mode_e;

  localparam logic [KIND_BITS-1:0] K_INT    = 5'd0;
  localparam logic [KIND_BITS-1:0] K_DEC    = 5'd1;
  localparam logic [KIND_BITS-1:0] K_IDENT  = 5'd2;
  localparam logic [KIND_BITS-1:0] K_KW0    = 5'd3;
  localparam logic [KIND_BITS-1:0] K_PLUS   = 5'd11;
  localparam logic [KIND_BITS-1:0] K_MINUS  = 5'd12;
  localparam logic [KIND_BITS-1:0] K_MUL    = 5'd13;
  localparam logic [KIND_BITS-1:0] K_DIV    = 5'd14;
  localparam logic [KIND_BITS-1:0] K_EQ     = 5'd15;
  localparam logic [KIND_BITS-1:0] K_EQEQ   = 5'd16;
  localparam logic [KIND_BITS-1:0] K_LBRACE = 5'd17;
  localparam logic [KIND_BITS-1:0] K_RBRACE = 5'd18;
  localparam logic [KIND_BITS-1:0] K_LPAREN = 5'd19;
  localparam logic [KIND_BITS-1:0] K_RPAREN = 5'd20;
  localparam logic [KIND_BITS-1:0] K_COMMA  = 5'd21;
  localparam logic [KIND_BITS-1:0] K_GT     = 5'd22;
  localparam logic [KIND_BITS-1:0] K_GE     = 5'd23;
  localparam logic [KIND_BITS-1:0] K_LT     = 5'd24;
  localparam logic [KIND_BITS-1:0] K_LE     = 5'd25;
  localparam logic [KIND_BITS-1:0] K_STRING = 5'd26;
  localparam logic [KIND_BITS-1:0] K_ERROR  = 5'd27;
  localparam logic [KIND_BITS-1:0] K_END    = 5'd28;

  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
    '{"w", "h", "i", "l", "e"},
    '{"p", "r", "i", "n", "t"},
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"},
    '{"n", "u", "l", "l", 8'h00},
    '{"f", "n", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00}
  };

  localparam logic [WLEN_BITS-1:0] KW_LEN [NUM_KW] = '{
    3'd5, 3'd5, 3'd4, 3'd5, 3'd4, 3'd2, 3'd2, 3'd4
  };

  typedef struct packed {
    logic [KIND_BITS-1:0]    kind;
    logic [OUT_POS_BITS-1:0] start_pos;
    logic [OUT_POS_BITS-1:0] end_pos;
    logic [LINE_BITS-1:0]    line;
    logic                    last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

endpackage

### sv/sts_kw_match.sv
// keyword candidate tracking and word token classification
module sts_kw_match (
  input  logic [7:0]                       byte_i,
  input  logic [sts_pkg::WLEN_BITS-1:0]    take_wlen_i,
  input  logic [sts_pkg::NUM_KW-1:0]       take_cand_i,
  output logic [sts_pkg::NUM_KW-1:0]       cand_o,
  input  logic [sts_pkg::WLEN_BITS-1:0]    cur_wlen_i,
  input  logic [sts_pkg::NUM_KW-1:0]       cur_cand_i,
  output logic [sts_pkg::KIND_BITS-1:0]    kind_o
);

  always_comb begin
    cand_o = take_cand_i;
    for (int k = 0; k < sts_pkg::NUM_KW; k++) begin
      if (take_wlen_i < sts_pkg::KW_LEN[k]) begin
        if (sts_pkg::KW_TEXT[k][take_wlen_i] != byte_i) begin
          cand_o[k] = 1'b0;
        end
      end else begin
        cand_o[k] = 1'b0;
      end
    end
  end

  // lowest matching keyword wins
  always_comb begin
    kind_o = sts_pkg::K_IDENT;
    for (int k = sts_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (cur_cand_i[k] && (cur_wlen_i == sts_pkg::KW_LEN[k])) begin
        kind_o = sts_pkg::K_KW0 + sts_pkg::KIND_BITS'(k);
      end
    end
  end

endmodule

### sv/sts_tok_fifo.sv
// small token queue between the scan step and the output channel
module sts_tok_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sts_pkg::push_t  push_i,
  output logic            room_o,
  output logic            out_valid_o,
  output sts_pkg::tok_t   out_tok_o,
  input  logic            pop_i
);

  localparam int Depth = sts_pkg::TOKQ_DEPTH;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  sts_pkg::tok_t   mem_q [Depth];
  logic [AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pop;

  assign pop         = pop_i && (cnt_q != '0);
  assign room_o      = (cnt_q <= CW'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rptr_q];

  assign wptr_d = wptr_q + AW'(push_i.cnt);
  assign rptr_d = rptr_q + AW'(pop);
  assign cnt_d  = cnt_q + CW'(push_i.cnt) - CW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_q + AW'(1)] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room_o)
    else $error("token queue pushed without room");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("token queue count out of range");
`endif

endmodule

### sv/script_token_scanner.sv
// script token scanner top level: input register, scan step, token queue
// flow: a beat is captured in the input register and scanned once the token
//   queue has room; the tokens it emits are offered from the token queue
// throughput: one input beat per cycle while the token queue holds two tokens or
//   fewer; a beat that closes a pending token and emits another pushes two tokens
// reset: mode idle, positions zero, line count and first_line back to one
module script_token_scanner #(
  parameter int POSITION_BITS = sts_pkg::POSITION_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [7:0]                        source_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sts_pkg::KIND_BITS-1:0]     token_kind_o,
  output logic [sts_pkg::OUT_POS_BITS-1:0]  start_pos_o,
  output logic [sts_pkg::OUT_POS_BITS-1:0]  end_pos_o,
  output logic [sts_pkg::LINE_BITS-1:0]     line_number_o,
  output logic                              last_of_run_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sts_pkg::CFG_BITS-1:0]      cfg_data_i
);

  localparam int PB = POSITION_BITS;
  localparam logic [sts_pkg::LINE_BITS-1:0] LineMax = '1;

  // input register
  logic            in_vld_q;
  logic            cmd_q;
  logic [7:0]      src_q;
  logic            step_fire;
  logic            room;

  // scan state
  sts_pkg::mode_e                  mode_q, mode_d;
  logic [PB-1:0]                   tstart_q, tstart_d;
  logic [PB-1:0]                   pos_q, pos_d, pos_inc;
  logic [sts_pkg::LINE_BITS-1:0]   line_q, line_d;
  logic [sts_pkg::WLEN_BITS-1:0]   wlen_q, wlen_d;
  logic [sts_pkg::NUM_KW-1:0]      cand_q, cand_d;
  logic [sts_pkg::CFG_BITS-1:0]    first_line_q;

  logic [sts_pkg::WLEN_BITS-1:0]   take_wlen;
  logic [sts_pkg::NUM_KW-1:0]      take_cand, cand_take;
  logic [sts_pkg::KIND_BITS-1:0]   word_kind;

  logic                            is_dig, is_alpha, is_wordc;
  logic                            e0_v, e1_v;
  sts_pkg::tok_t                   e0, e1;
  logic [sts_pkg::KIND_BITS-1:0]   pend_kind;
  sts_pkg::push_t                  push;
  sts_pkg::tok_t                   out_tok;

  function automatic logic [sts_pkg::OUT_POS_BITS-1:0] p24(input logic [PB-1:0] x);
    logic [PB+sts_pkg::OUT_POS_BITS-1:0] ext;
    ext = {{sts_pkg::OUT_POS_BITS{1'b0}}, x};
    return ext[sts_pkg::OUT_POS_BITS-1:0];
  endfunction

  assign step_fire   = in_vld_q && room;
  assign in_ready_o  = !in_vld_q || step_fire;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= command_i;
      src_q <= source_byte_i;
    end
  end

  assign is_dig   = src_q inside {["0":"9"]};
  assign is_alpha = src_q inside {["a":"z"], ["A":"Z"]};
  assign is_wordc = is_dig || is_alpha || (src_q == "_");
  assign pos_inc  = (pos_q == '1) ? pos_q : pos_q + PB'(1);

  assign take_wlen = (mode_q == sts_pkg::MODE_IDENT) ? wlen_q : '0;
  assign take_cand = (mode_q == sts_pkg::MODE_IDENT) ? cand_q : '1;

  sts_kw_match u_kw (
    .byte_i      (src_q),
    .take_wlen_i (take_wlen),
    .take_cand_i (take_cand),
    .cand_o      (cand_take),
    .cur_wlen_i  (wlen_q),
    .cur_cand_i  (cand_q),
    .kind_o      (word_kind)
  );

  always_comb begin
    case (mode_q)
      sts_pkg::MODE_NUMBER:  pend_kind = sts_pkg::K_INT;
      sts_pkg::MODE_DECIMAL: pend_kind = sts_pkg::K_DEC;
      sts_pkg::MODE_IDENT:   pend_kind = word_kind;
      sts_pkg::MODE_EQ:      pend_kind = sts_pkg::K_EQ;
      sts_pkg::MODE_GT:      pend_kind = sts_pkg::K_GT;
      sts_pkg::MODE_LT:      pend_kind = sts_pkg::K_LT;
      sts_pkg::MODE_STRING:  pend_kind = sts_pkg::K_STRING;
      default:               pend_kind = sts_pkg::K_ERROR;
    endcase
  end

  // one scan step: e0 is the flushed pending token, e1 the token this beat closes
  always_comb begin
    logic fresh;
    mode_d   = mode_q;
    tstart_d = tstart_q;
    pos_d    = pos_q;
    line_d   = line_q;
    wlen_d   = wlen_q;
    cand_d   = cand_q;
    fresh    = 1'b0;
    e0_v     = 1'b0;
    e1_v     = 1'b0;
    e0       = '{kind: pend_kind, start_pos: p24(tstart_q), end_pos: p24(pos_q),
                 line: line_q, last: 1'b0};
    e1       = '{kind: sts_pkg::K_END, start_pos: p24(tstart_q), end_pos: p24(pos_inc),
                 line: line_q, last: 1'b0};
    if (cmd_q) begin
      e0_v     = (mode_q != sts_pkg::MODE_IDLE);
      e1_v     = 1'b1;
      e1.start_pos = p24(pos_q);
      e1.end_pos   = p24(pos_q);
      mode_d   = sts_pkg::MODE_IDLE;
      tstart_d = '0;
      pos_d    = '0;
      line_d   = sts_pkg::LINE_BITS'(first_line_q);
      wlen_d   = '0;
      cand_d   = '1;
    end else begin
      pos_d = pos_inc;
      case (mode_q)
        sts_pkg::MODE_NUMBER: begin
          if (src_q == ".") begin
            mode_d = sts_pkg::MODE_DECIMAL;
          end else if (!is_dig) begin
            fresh = 1'b1;
          end
        end
        sts_pkg::MODE_DECIMAL: begin
          if (!is_dig) begin
            fresh = 1'b1;
          end
        end
        sts_pkg::MODE_IDENT: begin
          if (is_wordc) begin
            cand_d = cand_take;
            wlen_d = (wlen_q == '1) ? wlen_q : wlen_q + sts_pkg::WLEN_BITS'(1);
          end else begin
            fresh = 1'b1;
          end
        end
        sts_pkg::MODE_EQ, sts_pkg::MODE_GT, sts_pkg::MODE_LT: begin
          if (src_q == "=") begin
            e1_v   = 1'b1;
            mode_d = sts_pkg::MODE_IDLE;
            case (mode_q)
              sts_pkg::MODE_EQ: e1.kind = sts_pkg::K_EQEQ;
              sts_pkg::MODE_GT: e1.kind = sts_pkg::K_GE;
              default:          e1.kind = sts_pkg::K_LE;
            endcase
          end else begin
            fresh = 1'b1;
          end
        end
        sts_pkg::MODE_STRING: begin
          if ((src_q == "\"") || (src_q == 8'h00)) begin
            e1_v    = 1'b1;
            e1.kind = sts_pkg::K_STRING;
            mode_d  = sts_pkg::MODE_IDLE;
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      if (fresh) begin
        e0_v         = (mode_q != sts_pkg::MODE_IDLE);
        mode_d       = sts_pkg::MODE_IDLE;
        tstart_d     = pos_q;
        e1.start_pos = p24(pos_q);
        if (src_q == "\n") begin
          line_d = (line_q == LineMax) ? line_q : line_q + sts_pkg::LINE_BITS'(1);
        end else if (src_q inside {" ", "\t", 8'h0D}) begin
          mode_d = sts_pkg::MODE_IDLE;
        end else if (is_dig) begin
          mode_d = sts_pkg::MODE_NUMBER;
        end else if (is_alpha || (src_q == "_")) begin
          mode_d = sts_pkg::MODE_IDENT;
          wlen_d = sts_pkg::WLEN_BITS'(1);
          cand_d = cand_take;
        end else begin
          case (src_q)
            "=":     mode_d = sts_pkg::MODE_EQ;
            ">":     mode_d = sts_pkg::MODE_GT;
            "<":     mode_d = sts_pkg::MODE_LT;
            "\"":    mode_d = sts_pkg::MODE_STRING;
            "+":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_PLUS;   end
            "-":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_MINUS;  end
            "*":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_MUL;    end
            "/":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_DIV;    end
            "{":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_LBRACE; end
            "}":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_RBRACE; end
            "(":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_LPAREN; end
            ")":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_RPAREN; end
            ",":     begin e1_v = 1'b1; e1.kind = sts_pkg::K_COMMA;  end
            default: begin e1_v = 1'b1; e1.kind = sts_pkg::K_ERROR;  end
          endcase
        end
      end
    end
  end

  // pack emitted tokens in order, mark the final one
  always_comb begin
    push = '0;
    if (step_fire) begin
      if (e0_v) begin
        push.tok0      = e0;
        push.tok0.last = !e1_v;
        push.tok1      = e1;
        push.tok1.last = 1'b1;
        push.cnt       = e1_v ? 2'd2 : 2'd1;
      end else if (e1_v) begin
        push.tok0      = e1;
        push.tok0.last = 1'b1;
        push.cnt       = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= sts_pkg::MODE_IDLE;
      tstart_q     <= '0;
      pos_q        <= '0;
      line_q       <= sts_pkg::LINE_BITS'(1);
      wlen_q       <= '0;
      cand_q       <= '1;
      first_line_q <= sts_pkg::CFG_BITS'(1);
    end else begin
      if (step_fire) begin
        mode_q   <= mode_d;
        tstart_q <= tstart_d;
        pos_q    <= pos_d;
        line_q   <= line_d;
        wlen_q   <= wlen_d;
        cand_q   <= cand_d;
      end else if (cfg_valid_i && (pos_q == '0) && (mode_q == sts_pkg::MODE_IDLE)) begin
        line_q <= sts_pkg::LINE_BITS'(cfg_data_i);
      end
      if (cfg_valid_i) begin
        first_line_q <= cfg_data_i;
      end
    end
  end

  sts_tok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_tok_o   (out_tok),
    .pop_i       (out_ready_i)
  );

  assign token_kind_o  = out_tok.kind;
  assign start_pos_o   = out_tok.start_pos;
  assign end_pos_o     = out_tok.end_pos;
  assign line_number_o = out_tok.line;
  assign last_of_run_o = out_tok.last;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && cmd_q |=> (mode_q == sts_pkg::MODE_IDLE) && (pos_q == '0))
    else $error("end of source did not clear scan state");
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && cmd_q |-> (push.cnt != 2'd0) && e1_v)
    else $error("end of source produced no end token");
  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && !cmd_q |=> (pos_q == $past(pos_q) + PB'(1)) || (pos_q == '1))
    else $error("byte beat did not advance position");
`endif

endmodule

### verif/script_token_scanner_tb.sv
// testbench for script_token_scanner: directed table and random source text vs. a token predictor
`timescale 1ns / 1ps

module script_token_scanner_tb;
  import sts_pkg::*;

  localparam int BEAT_TARGET = 1900;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [POSITION_BITS-1:0] POS_TOP  = '1;
  localparam logic [LINE_BITS-1:0]     LINE_TOP = '1;

  typedef struct packed {
    logic [KIND_BITS-1:0]    kind;
    logic [OUT_POS_BITS-1:0] start_pos;
    logic [OUT_POS_BITS-1:0] end_pos;
    logic [LINE_BITS-1:0]    line_number;
    logic                    last_of_run;
  } token_t;

  typedef struct {
    logic       eos;
    logic [7:0] ch;
    logic       typed;
    token_t     want;
  } stim_row_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic                    command_i     = 1'b0;
  logic [7:0]              source_byte_i = 8'h00;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [KIND_BITS-1:0]    token_kind_o;
  logic [OUT_POS_BITS-1:0] start_pos_o;
  logic [OUT_POS_BITS-1:0] end_pos_o;
  logic [LINE_BITS-1:0]    line_number_o;
  logic                    last_of_run_o;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_BITS-1:0]     cfg_data_i    = '0;

  script_token_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .source_byte_i (source_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .start_pos_o   (start_pos_o),
    .end_pos_o     (end_pos_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  string kw_words [NUM_KW] = '{"while", "print", "true", "false", "null", "fn", "if", "else"};

  stim_row_t dir_rows [26] = '{
    '{1'b0, "+",      1'b1, '{K_PLUS,  24'd0, 24'd1, 24'd1, 1'b1}},
    '{1'b0, 8'hFF,    1'b1, '{K_ERROR, 24'd1, 24'd2, 24'd1, 1'b1}},
    '{1'b0, 8'h00,    1'b1, '{K_ERROR, 24'd2, 24'd3, 24'd1, 1'b1}},
    '{1'b0, CH_NL,    1'b0, '0},
    '{1'b0, "9",      1'b0, '0},
    '{1'b0, ".",      1'b0, '0},
    '{1'b0, "=",      1'b0, '0},
    '{1'b0, "=",      1'b0, '0},
    '{1'b0, "<",      1'b0, '0},
    '{1'b0, "x",      1'b0, '0},
    '{1'b0, ">",      1'b0, '0},
    '{1'b0, "=",      1'b0, '0},
    '{1'b0, CH_QUOTE, 1'b0, '0},
    '{1'b0, 8'h00,    1'b0, '0},
    '{1'b0, CH_QUOTE, 1'b0, '0},
    '{1'b0, CH_NL,    1'b0, '0},
    '{1'b0, 8'h80,    1'b0, '0},
    '{1'b1, 8'h5A,    1'b0, '0},
    '{1'b0, "p",      1'b0, '0},
    '{1'b0, "r",      1'b0, '0},
    '{1'b0, "i",      1'b0, '0},
    '{1'b0, "n",      1'b0, '0},
    '{1'b0, "t",      1'b0, '0},
    '{1'b0, "s",      1'b0, '0},
    '{1'b1, 8'hFF,    1'b0, '0},
    '{1'b1, 8'h00,    1'b1, '{K_END,   24'd0, 24'd0, 24'd1, 1'b1}}
  };

  // scanner state mirror
  mode_e                   scan_state;
  logic [POSITION_BITS-1:0] byte_pos;
  logic [POSITION_BITS-1:0] tok_first;
  logic [LINE_BITS-1:0]    line_cnt;
  logic [2:0]              word_len;
  logic [NUM_KW-1:0]       kw_alive;
  logic [CFG_BITS-1:0]     first_line_reg;
  token_t                  run_toks [2];
  int                      run_n;

  token_t     pending_tokens [$];
  logic [7:0] src_text [$];
  int         bad_tokens    = 0;
  int         beats_sent    = 0;
  int         src_idle_pct  = 35;
  int         sink_idle_pct = 35;
  int         hold_req      = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic void bump_pos();
    if (byte_pos != POS_TOP) byte_pos = byte_pos + 1'b1;
  endfunction

  function automatic void add_token(logic [KIND_BITS-1:0] kind,
                                    logic [POSITION_BITS-1:0] s,
                                    logic [POSITION_BITS-1:0] e);
    if (run_n < 2) begin
      run_toks[run_n] = '{kind, OUT_POS_BITS'(s), OUT_POS_BITS'(e), line_cnt, 1'b0};
      run_n++;
    end
  endfunction

  function automatic void restart_scan();
    scan_state = MODE_IDLE;
    tok_first  = '0;
    byte_pos   = '0;
    line_cnt   = LINE_BITS'(first_line_reg);
    word_len   = '0;
    kw_alive   = '1;
  endfunction

  function automatic void take_letter(logic [7:0] c);
    for (int k = 0; k < NUM_KW; k++) begin
      if (word_len >= kw_words[k].len() || kw_words[k][word_len] != c) kw_alive[k] = 1'b0;
    end
    if (word_len < 3'd7) word_len++;
  endfunction

  function automatic logic [KIND_BITS-1:0] word_token();
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_alive[k] && word_len == kw_words[k].len()) return KIND_BITS'(K_KW0 + k);
    end
    return K_IDENT;
  endfunction

  function automatic void close_pending();
    case (scan_state)
      MODE_NUMBER:  add_token(K_INT, tok_first, byte_pos);
      MODE_DECIMAL: add_token(K_DEC, tok_first, byte_pos);
      MODE_IDENT:   add_token(word_token(), tok_first, byte_pos);
      MODE_EQ:      add_token(K_EQ, tok_first, byte_pos);
      MODE_GT:      add_token(K_GT, tok_first, byte_pos);
      MODE_LT:      add_token(K_LT, tok_first, byte_pos);
      MODE_STRING:  add_token(K_STRING, tok_first, byte_pos);
      default: ;
    endcase
    scan_state = MODE_IDLE;
  endfunction

  function automatic void one_char(logic [KIND_BITS-1:0] kind);
    bump_pos();
    add_token(kind, tok_first, byte_pos);
  endfunction

  function automatic void scan_fresh(logic [7:0] c);
    tok_first = byte_pos;
    if (c == CH_NL) begin
      bump_pos();
      if (line_cnt != LINE_TOP) line_cnt++;
    end else if (c == " " || c == CH_TAB || c == CH_CR) begin
      bump_pos();
    end else if (is_digit(c)) begin
      scan_state = MODE_NUMBER;
      bump_pos();
    end else if (is_alpha(c) || c == "_") begin
      scan_state = MODE_IDENT;
      word_len   = '0;
      kw_alive   = '1;
      take_letter(c);
      bump_pos();
    end else begin
      case (c)
        "=":      begin scan_state = MODE_EQ; bump_pos(); end
        ">":      begin scan_state = MODE_GT; bump_pos(); end
        "<":      begin scan_state = MODE_LT; bump_pos(); end
        CH_QUOTE: begin scan_state = MODE_STRING; bump_pos(); end
        "+":      one_char(K_PLUS);
        "-":      one_char(K_MINUS);
        "*":      one_char(K_MUL);
        "/":      one_char(K_DIV);
        "{":      one_char(K_LBRACE);
        "}":      one_char(K_RBRACE);
        "(":      one_char(K_LPAREN);
        ")":      one_char(K_RPAREN);
        ",":      one_char(K_COMMA);
        default:  one_char(K_ERROR);
      endcase
    end
  endfunction

  function automatic void pair_check(logic [7:0] c, logic [KIND_BITS-1:0] kind);
    if (c == "=") begin
      bump_pos();
      add_token(kind, tok_first, byte_pos);
      scan_state = MODE_IDLE;
    end else begin
      close_pending();
      scan_fresh(c);
    end
  endfunction

  function automatic void tokenize_beat(logic eos, logic [7:0] c);
    run_n = 0;
    if (eos) begin
      close_pending();
      add_token(K_END, byte_pos, byte_pos);
      restart_scan();
    end else begin
      case (scan_state)
        MODE_NUMBER: begin
          if (is_digit(c)) bump_pos();
          else if (c == ".") begin
            scan_state = MODE_DECIMAL;
            bump_pos();
          end else begin
            close_pending();
            scan_fresh(c);
          end
        end
        MODE_DECIMAL: begin
          if (is_digit(c)) bump_pos();
          else begin
            close_pending();
            scan_fresh(c);
          end
        end
        MODE_IDENT: begin
          if (is_word(c)) begin
            take_letter(c);
            bump_pos();
          end else begin
            close_pending();
            scan_fresh(c);
          end
        end
        MODE_EQ: pair_check(c, K_EQEQ);
        MODE_GT: pair_check(c, K_GE);
        MODE_LT: pair_check(c, K_LE);
        MODE_STRING: begin
          bump_pos();
          if (c == CH_QUOTE || c == 8'h00) begin
            add_token(K_STRING, tok_first, byte_pos);
            scan_state = MODE_IDLE;
          end
        end
        default: scan_fresh(c);
      endcase
    end
    if (run_n > 0) run_toks[run_n-1].last_of_run = 1'b1;
  endfunction

  function automatic void queue_run();
    for (int i = 0; i < run_n; i++) pending_tokens.push_back(run_toks[i]);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int k;
    k = $urandom_range(52);
    if (k < 26) return 8'(8'h61 + k);
    else if (k < 52) return 8'(8'h41 + k - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(3))
      0, 1:    return " ";
      2:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_string_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if ($urandom_range(15) == 0) c = CH_NL;
    else if (c == CH_QUOTE) c = "'";
    return c;
  endfunction

  function automatic void report_token(string what, token_t want, token_t got);
    bad_tokens++;
    if (bad_tokens <= 10)
      $display("%s: expected kind %0d start %0d end %0d line %0d last %0d, got kind %0d start %0d end %0d line %0d last %0d",
               what, want.kind, want.start_pos, want.end_pos, want.line_number, want.last_of_run,
               got.kind, got.start_pos, got.end_pos, got.line_number, got.last_of_run);
  endfunction

  task automatic send_beat(input logic eos, input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= eos;
    source_byte_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    tokenize_beat(eos, c);
  endtask

  task automatic wait_drained();
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_first_line(input logic [CFG_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    first_line_reg = v;
    if (byte_pos == 0 && scan_state == MODE_IDLE) line_cnt = LINE_BITS'(v);
  endtask

  task automatic build_program(input int target, input bit noise);
    int    n;
    string w;
    string ops;
    src_text.delete();
    ops = "+-*/{}(),";
    while (src_text.size() < target) begin
      if (noise) begin
        src_text.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(11))
          0: repeat ($urandom_range(1, 4)) src_text.push_back(rand_digit());
          1: begin
            repeat ($urandom_range(1, 3)) src_text.push_back(rand_digit());
            src_text.push_back(".");
            repeat ($urandom_range(0, 3)) src_text.push_back(rand_digit());
          end
          2: begin
            src_text.push_back(rand_letter());
            repeat ($urandom_range(0, 7))
              src_text.push_back($urandom_range(2) == 0 ? rand_digit() : rand_letter());
          end
          3, 4: begin
            // keywords, their prefixes and longer words built on them
            w = kw_words[$urandom_range(NUM_KW - 1)];
            n = ($urandom_range(3) == 0) ? $urandom_range(1, w.len()) : w.len();
            for (int i = 0; i < n; i++) src_text.push_back(w[i]);
            if ($urandom_range(3) == 0) src_text.push_back(rand_letter());
          end
          5: src_text.push_back(ops[$urandom_range(ops.len() - 1)]);
          6: begin
            w = "=<>";
            src_text.push_back(w[$urandom_range(2)]);
            if ($urandom_range(1)) src_text.push_back("=");
          end
          7: begin
            src_text.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6)) src_text.push_back(rand_string_char());
            src_text.push_back($urandom_range(4) == 0 ? 8'h00 : CH_QUOTE);
          end
          8: begin
            case ($urandom_range(3))
              0:       src_text.push_back(8'($urandom_range(128, 255)));
              1:       src_text.push_back(".");
              2:       src_text.push_back(8'($urandom_range(1, 8)));
              default: src_text.push_back(8'h00);
            endcase
          end
          9, 10:   src_text.push_back(rand_blank());
          default: src_text.push_back(CH_NL);
        endcase
        if ($urandom_range(1)) src_text.push_back(rand_blank());
      end
    end
  endtask

  task automatic run_program(input int target, input bit noise, input bit pause_mid);
    build_program(target, noise);
    foreach (src_text[i]) begin
      if (pause_mid && i == src_text.size() / 2) begin
        // mid-source write only takes effect at the next end of source
        in_valid_i <= 1'b0;
        wait_drained();
        write_first_line(CFG_BITS'($urandom_range(65535)));
      end
      send_beat(1'b0, src_text[i]);
      queue_run();
    end
    send_beat(1'b1, 8'($urandom_range(255)));
    queue_run();
    beats_sent += src_text.size() + 1;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_first_line(int idx);
    case (idx % 5)
      0:       return '0;
      1:       return '1;
      3:       return CFG_BITS'(1);
      default: return CFG_BITS'($urandom_range(65535));
    endcase
  endfunction

  always @(posedge clk_i) begin : check_tokens
    token_t got;
    token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{token_kind_o, start_pos_o, end_pos_o, line_number_o, last_of_run_o};
      if (pending_tokens.size() == 0) begin
        report_token("unexpected token", '0, got);
      end else begin
        want = pending_tokens.pop_front();
        if (got !== want) report_token("token mismatch", want, got);
      end
    end
  end

  initial begin : sink
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int prog;
    first_line_reg = CFG_BITS'(1);
    restart_scan();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      send_beat(dir_rows[r].eos, dir_rows[r].ch);
      if (dir_rows[r].typed) pending_tokens.push_back(dir_rows[r].want);
      else queue_run();
    end

    prog = 0;
    while (beats_sent < BEAT_TARGET) begin
      if (prog % 6 == 0) begin
        in_valid_i <= 1'b0;
        wait_drained();
        write_first_line(pick_first_line(prog / 6));
      end
      src_idle_pct  = (prog >= 10 && prog < 16) ? 0 : 35;
      sink_idle_pct = src_idle_pct;
      if (prog == 4) begin
        // receiver stalls long while beats keep coming
        src_idle_pct = 0;
        hold_req = HOLD_CYCLES;
      end
      run_program(prog == 4 ? 60 : $urandom_range(10, 60), $urandom_range(99) < 12, prog == 3);
      prog++;
    end
    in_valid_i <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bad_tokens == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
